// File: hdl/mlfq_pkg.sv
// Shared types and constants for the multilevel feedback queue scheduler.
// Holds the item structs, the controller states and the command and status bundles.
// No dependencies.
package mlfq_pkg;

   localparam int ID_W        = 4;
   localparam int LEVEL_W     = 3;
   localparam int RUNTIME_W   = 8;
   localparam int DIV_W       = 8;
   localparam int SCALE_W     = 4;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 8;

   localparam logic [1:0] MODE_TICK  = 2'd0;
   localparam logic [1:0] MODE_ADMIT = 2'd1;
   localparam logic [1:0] MODE_START = 2'd2;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_TICK_DIVISOR = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SLICE_SCALE  = 2'd1;

   localparam logic [DIV_W-1:0]   DIV_RESET   = 8'd18;
   localparam logic [SCALE_W-1:0] SCALE_RESET = 4'd2;

   typedef struct packed {
      logic [1:0]      mode;
      logic [ID_W-1:0] thread_id;
   } req_type;

   typedef struct packed {
      logic               switched;
      logic               current_valid;
      logic [ID_W-1:0]    current_id;
      logic [LEVEL_W-1:0] current_level;
      logic [1:0]         status;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_AGE,
      ST_PUSH,
      ST_POP_RD,
      ST_POP_DATA,
      ST_POP_LVL,
      ST_RESPOND
   } state_type;

   typedef struct packed {
      logic       accept;
      logic       admit;
      logic       tick;
      logic       age;
      logic       push;
      logic       pop;
      logic       load_run;
      logic       load_level;
      logic       tsel_pop;
      logic       set_switched;
      logic       set_status;
      logic [1:0] status;
      logic       respond;
   } cmd_type;

   typedef struct packed {
      logic [1:0] mode;
      logic       admit_full;
      logic       slice_end;
      logic       run_valid;
      logic       any_ready;
      logic       push_full;
   } stat_type;

endpackage

// File: hdl/mlfq_ctrl.sv
// Controller state machine of the scheduler.
// Sequences admit, start and tick items into datapath commands.
// Depends on mlfq_pkg.
module mlfq_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  mlfq_pkg::stat_type stat,
   output mlfq_pkg::cmd_type  cmd,
   output logic               busy
);
   import mlfq_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      cmd.status = STATUS_OK;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.accept = 1'b1;
               state_in   = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            state_in = ST_RESPOND;
            unique case (stat.mode)
               MODE_ADMIT: begin
                  if (stat.admit_full) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = STATUS_FULL;
                  end else begin
                     cmd.admit = 1'b1;
                  end
               end
               MODE_START: begin
                  if (!stat.run_valid) begin
                     if (stat.any_ready) begin
                        cmd.set_switched = 1'b1;
                        state_in         = ST_POP_RD;
                     end else begin
                        cmd.set_status = 1'b1;
                        cmd.status     = STATUS_EMPTY;
                     end
                  end
               end
               MODE_TICK: begin
                  cmd.tick = 1'b1;
                  if (stat.slice_end) begin
                     if (stat.run_valid) begin
                        state_in = ST_AGE;
                     end else begin
                        cmd.set_status = 1'b1;
                        cmd.status     = STATUS_EMPTY;
                     end
                  end
               end
               default: ;
            endcase
         end
         ST_AGE: begin
            cmd.age  = 1'b1;
            state_in = ST_PUSH;
         end
         ST_PUSH: begin
            if (stat.push_full) begin
               state_in = ST_RESPOND;
            end else begin
               cmd.push         = 1'b1;
               cmd.set_switched = 1'b1;
               state_in         = ST_POP_RD;
            end
         end
         ST_POP_RD: begin
            cmd.pop  = 1'b1;
            state_in = ST_POP_DATA;
         end
         ST_POP_DATA: begin
            cmd.load_run = 1'b1;
            cmd.tsel_pop = 1'b1;
            state_in     = ST_POP_LVL;
         end
         ST_POP_LVL: begin
            cmd.load_level = 1'b1;
            state_in       = ST_RESPOND;
         end
         ST_RESPOND: begin
            cmd.respond = 1'b1;
            state_in    = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

// File: hdl/mlfq_dp.sv
// Datapath of the scheduler: level queues, thread table, running thread and result register.
// Acts on commands from mlfq_ctrl and reports status back to it.
// Depends on mlfq_pkg.
module mlfq_dp #(
   parameter int NUM_LEVELS  = 5,
   parameter int NUM_THREADS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  mlfq_pkg::req_type                    req_data,
   input  mlfq_pkg::cmd_type                    cmd,
   output mlfq_pkg::stat_type                   stat,
   input  logic                                 csr_write,
   input  logic [mlfq_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [mlfq_pkg::CSR_DATA_W-1:0]      csr_data,
   output logic                                 rsp_valid,
   output mlfq_pkg::rsp_type                    rsp_data
);
   import mlfq_pkg::*;

   localparam int SW     = $clog2(NUM_THREADS);
   localparam int LVW    = $clog2(NUM_LEVELS);
   localparam int CW     = $clog2(NUM_THREADS + 1);
   localparam int QAW    = LVW + SW;
   localparam int QDEPTH = 2 ** QAW;
   localparam int TW     = LVW + RUNTIME_W;
   localparam int IDS    = 2 ** ID_W;

   function automatic logic [SW-1:0] wrap_next(input logic [SW-1:0] p);
      return (p == SW'(NUM_THREADS - 1)) ? '0 : p + 1'b1;
   endfunction

   logic [DIV_W-1:0]     divisor_ff;
   logic [SCALE_W-1:0]   scale_ff;
   req_type              req_ff;
   logic [SW-1:0]        tid_map [IDS];
   logic [SW-1:0]        tid;

   logic                 run_valid_ff;
   logic [SW-1:0]        run_slot_ff;
   logic [LVW-1:0]       cur_level_ff;
   logic [DIV_W-1:0]     prescale_ff;
   logic [DIV_W-1:0]     prescale_inc;
   logic                 slice_end;

   logic [SW-1:0]        head_ff  [NUM_LEVELS];
   logic [SW-1:0]        tail_ff  [NUM_LEVELS];
   logic [CW-1:0]        count_ff [NUM_LEVELS];
   logic [NUM_LEVELS-1:0] nonempty;
   logic [LVW-1:0]       pop_lvl;
   logic [LVW-1:0]       lvl_ff;
   logic [LVW-1:0]       w_lvl;
   logic [SW-1:0]        w_slot;
   logic                 q_we;
   logic                 push_full;
   logic                 admit_full;

   logic [SW-1:0]        qmem_ff [QDEPTH];
   logic [SW-1:0]        q_rd_ff;
   logic [QAW-1:0]       q_waddr;
   logic [QAW-1:0]       q_raddr;

   logic [TW-1:0]        tmem_ff [NUM_THREADS];
   logic [NUM_THREADS-1:0] tvalid_ff;
   logic [TW-1:0]        t_rd_ff;
   logic                 t_rd_valid_ff;
   logic [SW-1:0]        t_raddr;
   logic [SW-1:0]        t_waddr;
   logic [TW-1:0]        t_wdata;
   logic                 t_we;
   logic [LVW-1:0]       rd_lvl;
   logic [RUNTIME_W-1:0] rd_rt;

   logic [LVW:0]         lvl_p1;
   logic [RUNTIME_W-1:0] quantum;
   logic [RUNTIME_W-1:0] rt_inc;
   logic                 demote;
   logic [RUNTIME_W-1:0] age_rt;
   logic [LVW-1:0]       age_lvl;

   logic                 switched_ff;
   logic [1:0]           status_ff;
   logic                 rsp_valid_ff;
   rsp_type              rsp_data_ff;
   rsp_type              rsp_next;
   logic [SW+ID_W-1:0]   slot_ext;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         divisor_ff <= DIV_RESET;
         scale_ff   <= SCALE_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_TICK_DIVISOR: divisor_ff <= csr_data[DIV_W-1:0];
            CSR_SLICE_SCALE:  scale_ff   <= csr_data[SCALE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         req_ff <= req_data;
      end
   end

   // fold the thread id into the slot range
   for (genvar i = 0; i < IDS; i++) begin : g_tid
      assign tid_map[i] = SW'(i % NUM_THREADS);
   end
   assign tid = tid_map[req_ff.thread_id];

   assign prescale_inc = prescale_ff + 1'b1;
   assign slice_end    = (prescale_inc >= divisor_ff);

   // queue bookkeeping
   always_comb begin
      for (int l = 0; l < NUM_LEVELS; l++) begin
         nonempty[l] = (count_ff[l] != '0);
      end
      pop_lvl = '0;
      for (int l = NUM_LEVELS - 1; l >= 0; l--) begin
         if (nonempty[l]) begin
            pop_lvl = LVW'(l);
         end
      end
   end

   assign q_we       = cmd.admit | cmd.push;
   assign w_lvl      = cmd.admit ? '0 : lvl_ff;
   assign w_slot     = cmd.admit ? tid : run_slot_ff;
   assign push_full  = (count_ff[lvl_ff] == CW'(NUM_THREADS));
   assign admit_full = (count_ff[0] == CW'(NUM_THREADS));
   assign q_waddr    = {w_lvl, tail_ff[w_lvl]};
   assign q_raddr    = {pop_lvl, head_ff[pop_lvl]};

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int l = 0; l < NUM_LEVELS; l++) begin
            head_ff[l]  <= '0;
            tail_ff[l]  <= '0;
            count_ff[l] <= '0;
         end
      end else begin
         for (int l = 0; l < NUM_LEVELS; l++) begin
            if (q_we && (w_lvl == LVW'(l))) begin
               tail_ff[l]  <= wrap_next(tail_ff[l]);
               count_ff[l] <= count_ff[l] + 1'b1;
            end else if (cmd.pop && (pop_lvl == LVW'(l))) begin
               head_ff[l]  <= wrap_next(head_ff[l]);
               count_ff[l] <= count_ff[l] - 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_we) begin
         qmem_ff[q_waddr] <= w_slot;
      end
      q_rd_ff <= qmem_ff[q_raddr];
   end

   // thread table: level and runtime per slot
   assign t_raddr = cmd.tsel_pop ? q_rd_ff : run_slot_ff;
   assign t_we    = cmd.admit | cmd.age;
   assign t_waddr = cmd.admit ? tid : run_slot_ff;
   assign t_wdata = cmd.admit ? '0 : {age_lvl, age_rt};

   always_ff @(posedge clock) begin
      if (t_we) begin
         tmem_ff[t_waddr] <= t_wdata;
      end
      t_rd_ff <= tmem_ff[t_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tvalid_ff     <= '0;
         t_rd_valid_ff <= 1'b0;
      end else begin
         if (t_we) begin
            tvalid_ff[t_waddr] <= 1'b1;
         end
         t_rd_valid_ff <= tvalid_ff[t_raddr];
      end
   end

   assign rd_lvl = t_rd_valid_ff ? t_rd_ff[TW-1:RUNTIME_W] : '0;
   assign rd_rt  = t_rd_valid_ff ? t_rd_ff[RUNTIME_W-1:0] : '0;

   // advance runtime, demote at the end of the quantum
   assign lvl_p1  = {1'b0, rd_lvl} + 1'b1;
   assign quantum = RUNTIME_W'(lvl_p1) * RUNTIME_W'(scale_ff);
   assign rt_inc  = rd_rt + 1'b1;
   assign demote  = (rt_inc >= quantum);
   assign age_rt  = demote ? '0 : rt_inc;
   assign age_lvl = (demote && (rd_lvl != LVW'(NUM_LEVELS - 1))) ? rd_lvl + 1'b1 : rd_lvl;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_valid_ff <= 1'b0;
         run_slot_ff  <= '0;
         cur_level_ff <= '0;
         prescale_ff  <= '0;
         lvl_ff       <= '0;
      end else begin
         if (cmd.tick) begin
            prescale_ff <= slice_end ? '0 : prescale_inc;
         end
         if (cmd.age) begin
            lvl_ff       <= age_lvl;
            cur_level_ff <= age_lvl;
         end
         if (cmd.load_run) begin
            run_valid_ff <= 1'b1;
            run_slot_ff  <= q_rd_ff;
         end
         if (cmd.load_level) begin
            cur_level_ff <= rd_lvl;
         end
         if (cmd.admit && run_valid_ff && (tid == run_slot_ff)) begin
            cur_level_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         switched_ff <= 1'b0;
         status_ff   <= STATUS_OK;
      end else if (cmd.accept) begin
         switched_ff <= 1'b0;
         status_ff   <= STATUS_OK;
      end else begin
         if (cmd.set_switched) begin
            switched_ff <= 1'b1;
         end
         if (cmd.set_status) begin
            status_ff <= cmd.status;
         end
      end
   end

   assign slot_ext = {{ID_W{1'b0}}, run_slot_ff};

   always_comb begin
      rsp_next.switched      = switched_ff;
      rsp_next.current_valid = run_valid_ff;
      rsp_next.current_id    = run_valid_ff ? slot_ext[ID_W-1:0] : '0;
      rsp_next.current_level = run_valid_ff ? LEVEL_W'(cur_level_ff) : '0;
      rsp_next.status        = status_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.respond;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.respond) begin
         rsp_data_ff <= rsp_next;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign stat.mode       = req_ff.mode;
   assign stat.admit_full = admit_full;
   assign stat.slice_end  = slice_end;
   assign stat.run_valid  = run_valid_ff;
   assign stat.any_ready  = |nonempty;
   assign stat.push_full  = push_full;

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result strobe held for more than one cycle");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.pop |-> stat.any_ready)
      else $error("pop issued with all queues empty");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      cmd.push |-> !push_full)
      else $error("push issued into a full queue");

   a_switch_running: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!rsp_data_ff.switched || rsp_data_ff.current_valid))
      else $error("switch reported with no running thread");

   a_full_from_admit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_data_ff.status == STATUS_FULL)) |-> (req_ff.mode == MODE_ADMIT))
      else $error("queue full status on an item that is not an admit");

endmodule

// File: hdl/mlfq_thread_scheduler.sv
// Top level of the multilevel feedback queue thread scheduler.
// Joins the controller mlfq_ctrl and the datapath mlfq_dp; depends on mlfq_pkg.
//
// An item is taken when start is high and busy is low; busy stays high until its result
// has been registered, and the result is shown for one cycle with rsp_valid and must be
// taken then, since there is no back-pressure. A tick that does not end a slice, an
// admit, a start while running and any item that reports an empty or full status go
// straight from the decision to the result. A start that picks a thread reads the queue
// memory and then the thread table. A slice end ages the running thread with a
// read-modify-write of the thread table, pushes it back and, unless its queue is full,
// switches like a start. The next item can be taken in the cycle the result is shown.
// Configuration writes are always ready and are meant to arrive while the block is idle.
module mlfq_thread_scheduler #(
   parameter int NUM_LEVELS  = 5,
   parameter int NUM_THREADS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  mlfq_pkg::req_type                req_data,
   output logic                             rsp_valid,
   output mlfq_pkg::rsp_type                rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [mlfq_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [mlfq_pkg::CSR_DATA_W-1:0]  csr_data
);
   import mlfq_pkg::*;

   cmd_type  cmd;
   stat_type stat;
   logic     ctrl_busy;

   mlfq_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .cmd   (cmd),
      .busy  (ctrl_busy)
   );

   mlfq_dp #(
      .NUM_LEVELS  (NUM_LEVELS),
      .NUM_THREADS (NUM_THREADS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .csr_write (csr_valid & csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   assign busy      = ctrl_busy;
   assign csr_ready = 1'b1;

endmodule

// File: dv/tb_mlfq_thread_scheduler.sv
`timescale 1ns / 1ps
// Self-checking testbench for mlfq_thread_scheduler: a scoreboard class predicts each result
// from its own copy of the queues, threads and registers; plain tasks drive items and writes.
// Depends on mlfq_pkg and the mlfq_thread_scheduler RTL.
module tb_mlfq_thread_scheduler;
   import mlfq_pkg::*;

   localparam int NUM_LEVELS  = 5;
   localparam int NUM_THREADS = 16;
   localparam int PHASES      = 8;
   localparam int PHASE_ITEMS = 140;
   localparam int SETTLE      = 8;
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   class sched_scoreboard;
      logic [DIV_W-1:0]     tick_divisor;
      logic [SCALE_W-1:0]   slice_scale;
      logic [7:0]           prescale;
      bit                   running;
      logic [ID_W-1:0]      run_slot;
      logic [LEVEL_W-1:0]   level_of [NUM_THREADS];
      logic [RUNTIME_W-1:0] runtime_of [NUM_THREADS];
      logic [ID_W-1:0]      ring [NUM_LEVELS][NUM_THREADS];
      logic [ID_W-1:0]      head [NUM_LEVELS];
      logic [ID_W-1:0]      tail [NUM_LEVELS];
      logic [4:0]           depth [NUM_LEVELS];
      rsp_type              expected_views [$];
      int                   failures;

      function new();
         tick_divisor = DIV_RESET;
         slice_scale  = SCALE_RESET;
         prescale     = '0;
         running      = 1'b0;
         run_slot     = '0;
         failures     = 0;
         for (int i = 0; i < NUM_THREADS; i++) begin
            level_of[i]   = '0;
            runtime_of[i] = '0;
         end
         for (int l = 0; l < NUM_LEVELS; l++) begin
            head[l]  = '0;
            tail[l]  = '0;
            depth[l] = '0;
         end
      endfunction

      function void write_register(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         if (idx == CSR_TICK_DIVISOR)
            tick_divisor = val;
         else if (idx == CSR_SLICE_SCALE)
            slice_scale = val[SCALE_W-1:0];
      endfunction

      function bit enqueue(int lvl, logic [ID_W-1:0] slot);
         if (depth[lvl] >= NUM_THREADS)
            return 1'b0;
         ring[lvl][tail[lvl]] = slot;
         tail[lvl] = (tail[lvl] == NUM_THREADS - 1) ? '0 : tail[lvl] + 1'b1;
         depth[lvl] = depth[lvl] + 1'b1;
         return 1'b1;
      endfunction

      function bit dequeue(output logic [ID_W-1:0] slot);
         slot = '0;
         for (int l = 0; l < NUM_LEVELS; l++) begin
            if (depth[l] != 0) begin
               slot = ring[l][head[l]];
               head[l] = (head[l] == NUM_THREADS - 1) ? '0 : head[l] + 1'b1;
               depth[l] = depth[l] - 1'b1;
               return 1'b1;
            end
         end
         return 1'b0;
      endfunction

      function void age(logic [ID_W-1:0] s);
         int quantum;
         quantum = (int'(level_of[s]) + 1) * int'(slice_scale);
         runtime_of[s] = runtime_of[s] + 1'b1;
         if (int'(runtime_of[s]) >= quantum) begin
            runtime_of[s] = '0;
            if (level_of[s] < NUM_LEVELS - 1)
               level_of[s] = level_of[s] + 1'b1;
         end
      endfunction

      function rsp_type next_view(req_type item);
         rsp_type         v;
         logic [ID_W-1:0] slot;
         v = '0;
         case (item.mode)
            MODE_ADMIT: begin
               if (depth[0] >= NUM_THREADS) begin
                  v.status = STATUS_FULL;
               end else begin
                  level_of[item.thread_id]   = '0;
                  runtime_of[item.thread_id] = '0;
                  void'(enqueue(0, item.thread_id));
               end
            end
            MODE_START: begin
               if (!running) begin
                  if (dequeue(slot)) begin
                     run_slot   = slot;
                     running    = 1'b1;
                     v.switched = 1'b1;
                  end else begin
                     v.status = STATUS_EMPTY;
                  end
               end
            end
            MODE_TICK: begin
               prescale = prescale + 1'b1;
               if (prescale >= tick_divisor) begin
                  prescale = '0;
                  if (!running) begin
                     v.status = STATUS_EMPTY;
                  end else begin
                     age(run_slot);
                     if (enqueue(level_of[run_slot], run_slot) && dequeue(slot)) begin
                        run_slot   = slot;
                        v.switched = 1'b1;
                     end
                  end
               end
            end
            default: ;
         endcase
         v.current_valid = running;
         if (running) begin
            v.current_id    = run_slot;
            v.current_level = level_of[run_slot];
         end
         return v;
      endfunction

      function void note_request(req_type item);
         expected_views.push_back(next_view(item));
      endfunction

      function bit field_ok(string name, logic [7:0] want, logic [7:0] got);
         if (got !== want) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            return 1'b0;
         end
         return 1'b1;
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         bit      ok;
         if (expected_views.size() == 0) begin
            $display("%0t: unexpected result expected none actual %p", $time, got);
            failures++;
            return;
         end
         want = expected_views.pop_front();
         ok = field_ok("switched", want.switched, got.switched);
         ok = field_ok("current_valid", want.current_valid, got.current_valid) && ok;
         ok = field_ok("current_id", want.current_id, got.current_id) && ok;
         ok = field_ok("current_level", want.current_level, got.current_level) && ok;
         ok = field_ok("status", want.status, got.status) && ok;
         if (!ok)
            failures++;
      endfunction

      function int awaiting();
         return expected_views.size();
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   start;
   logic                   busy;
   req_type                req_data;
   logic                   rsp_valid;
   rsp_type                rsp_data;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   sched_scoreboard sb;

   mlfq_thread_scheduler i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid)
         sb.check_response(rsp_data);
   end

   task automatic send_item(req_type item);
      req_data <= item;
      start    <= 1'b1;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      sb.note_request(item);
   endtask

   task automatic program_register(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      start <= 1'b0;
      while (sb.awaiting() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_valid <= 1'b0;
      sb.write_register(idx, val);
   endtask

   initial begin
      #1_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      req_type    item;
      int         pick;
      int         gap_pct;
      logic [7:0] div_plan [PHASES];
      logic [7:0] scale_plan [PHASES];
      sb = new();
      div_plan   = '{8'd1, 8'd255, 8'd2, 8'd1, 8'd18, 8'd3, 8'd1, 8'd1};
      scale_plan = '{8'd1, 8'd15, 8'd3, 8'd15, 8'd2, 8'd1, 8'd1, 8'd1};
      reset     <= 1'b1;
      start     <= 1'b0;
      req_data  <= '0;
      csr_valid <= 1'b0;
      csr_index <= '0;
      csr_data  <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty start, unused mode and a tick that stays inside the slice
      send_item('{mode: MODE_START, thread_id: 4'd0});
      send_item('{mode: MODE_UNUSED, thread_id: 4'd15});
      send_item('{mode: MODE_TICK, thread_id: 4'd0});
      program_register(CSR_TICK_DIVISOR, 8'd1);
      send_item('{mode: MODE_TICK, thread_id: 4'd15});
      for (int i = 0; i < NUM_THREADS; i++)
         send_item('{mode: MODE_ADMIT, thread_id: i[ID_W-1:0]});
      send_item('{mode: MODE_ADMIT, thread_id: 4'd9});
      send_item('{mode: MODE_START, thread_id: 4'd0});
      send_item('{mode: MODE_START, thread_id: 4'd7});
      send_item('{mode: MODE_ADMIT, thread_id: 4'd3});
      send_item('{mode: MODE_TICK, thread_id: 4'd0});
      send_item('{mode: MODE_TICK, thread_id: 4'd0});

      for (int p = 0; p < PHASES; p++) begin
         if (p == 6) begin
            div_plan[p]   = 8'($urandom_range(1, 6));
            scale_plan[p] = 8'($urandom_range(1, 15));
         end
         program_register(CSR_TICK_DIVISOR, div_plan[p]);
         program_register(CSR_SLICE_SCALE, scale_plan[p]);
         gap_pct = (p == PHASES - 1) ? 0 : $urandom_range(10, 40);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            pick = $urandom_range(0, 99);
            item.thread_id = ID_W'($urandom_range(0, NUM_THREADS - 1));
            if (pick < 62)
               item.mode = MODE_TICK;
            else if (pick < 80)
               item.mode = MODE_ADMIT;
            else if (pick < 92)
               item.mode = MODE_START;
            else
               item.mode = MODE_UNUSED;
            send_item(item);
            if (p == 2 && n == PHASE_ITEMS / 2) begin
               start <= 1'b0;
               while (sb.awaiting() != 0)
                  @(posedge clock);
            end else if ($urandom_range(0, 99) < gap_pct) begin
               start <= 1'b0;
               repeat ($urandom_range(1, 17)) @(posedge clock);
            end
         end
      end

      start <= 1'b0;
      while (sb.awaiting() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (sb.failures == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
